/* design/uvbc_pkg.sv */
// Shared types and constants for the UV background calibrator.
`default_nettype none
package uvbc_pkg;

    localparam int READING_W = 12;
    localparam int LEVEL_W   = 8;
    localparam int STORE_W   = 20;

    // Full scale of the calibrated level and the scaling shift (times 256)
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam int SCALE_SHIFT = 8;

    localparam logic [STORE_W-1:0] STORE_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_AVERAGE = 2'd1,
        OP_MEASURE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLACK = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        op_t                  op;
        logic [READING_W-1:0] first_reading;
        logic [READING_W-1:0] second_reading;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   scaled_level;
        logic [READING_W-1:0] raw_difference;
        logic [STORE_W-1:0]   background_level;
    } out_item_t;

    // Divider handshake toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

/* design/uvbc_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module uvbc_serial_div
    import uvbc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [STORE_W-1:0]   dividend,
    input  wire logic [READING_W-1:0] divisor,
    output div_status_t               status,
    output logic [STORE_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(STORE_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STORE_W - 1);

    logic [STORE_W-1:0]   quo_reg;
    logic [READING_W-1:0] rem_reg;
    logic [READING_W-1:0] div_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [READING_W:0] partial;
    logic [READING_W:0] trial;
    logic               fits;

    // Shift the next dividend bit into the remainder and try a subtract
    always_comb
    begin
        partial = {rem_reg, quo_reg[STORE_W-1]};
        trial   = partial - {1'b0, div_reg};
        fits    = partial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[STORE_W-2:0], fits};
            rem_reg <= fits ? trial[READING_W-1:0] : partial[READING_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule
`default_nettype wire

/* design/uv_background_calibrator.sv */
// Top level of the UV background calibrator: control, background state, output register.
`default_nettype none
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------------
//  in      | in_valid / in_ready   | in_item: op, first/second reading
//  out     | out_valid / out_ready | out_item: scaled level, raw diff, background
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (white, black level)
//
//  Ops that need a quotient (average with samples, measure with a positive span)
//  pass from accept through ST_EXEC (divider start), ST_DIV (the serial divider
//  works out the quotient bit by bit and it is picked up on done) and ST_FIN.
//  Other ops pass through ST_EXEC and ST_FIN. One item is in work at a time; the
//  next item is accepted the cycle after the result moves into the output register.
//  Reset clears background sum and count; a stalled output holds the finish step.
//
module uv_background_calibrator
    import uvbc_pkg::*;
#(
    parameter int MAX_BACKGROUND_SAMPLES = 256
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [READING_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(MAX_BACKGROUND_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BACKGROUND_SAMPLES);

    ctrl_state_t state_reg, state_next;

    in_item_t             item_reg;
    logic [READING_W-1:0] white_reg;
    logic [READING_W-1:0] black_reg;
    logic [STORE_W-1:0]   store_reg;
    logic [CNT_W-1:0]     count_reg;

    // Result waiting for the output register
    logic [LEVEL_W-1:0]   res_level_reg;
    logic [STORE_W-1:0]   res_store_reg;
    logic [CNT_W-1:0]     res_count_reg;

    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    logic                 div_start;
    div_status_t          div_status;
    logic [STORE_W-1:0]   div_dividend;
    logic [READING_W-1:0] div_divisor;
    logic [STORE_W-1:0]   quotient;

    logic [READING_W-1:0] diff;
    logic [READING_W-1:0] net;
    logic [READING_W-1:0] span;
    logic                 span_neg;
    logic                 span_zero;
    logic [STORE_W:0]     sum;
    logic                 need_div;
    logic                 out_load;

    // Datapath for the item in work
    always_comb
    begin
        diff = (item_reg.second_reading >= item_reg.first_reading)
             ? item_reg.second_reading - item_reg.first_reading : '0;
        // Below background floors at zero; store is then under 4096
        net  = ({{(STORE_W-READING_W){1'b0}}, diff} > store_reg)
             ? diff - store_reg[READING_W-1:0] : '0;
        span      = white_reg - black_reg;
        span_neg  = white_reg < black_reg;
        span_zero = white_reg == black_reg;
        sum       = {1'b0, store_reg} + {{(STORE_W+1-READING_W){1'b0}}, diff};
        need_div  = ((item_reg.op == OP_AVERAGE) && (count_reg != '0))
                 || ((item_reg.op == OP_MEASURE) && !span_neg && !span_zero);
        if (item_reg.op == OP_AVERAGE)
        begin
            div_dividend = store_reg;
            div_divisor  = {{(READING_W-CNT_W){1'b0}}, count_reg};
        end
        else
        begin
            div_dividend = {net, {SCALE_SHIFT{1'b0}}};
            div_divisor  = span;
        end
        out_load = !out_valid_reg || out_ready;
    end

    // Control
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (need_div)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Reference levels, background state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg     <= '1;
            black_reg     <= '0;
            store_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_WHITE)
                begin
                    white_reg <= cfg_data;
                end
                else if (cfg_index == REG_BLACK)
                begin
                    black_reg <= cfg_data;
                end
            end
            if ((state_reg == ST_FIN) && out_load)
            begin
                store_reg     <= res_store_reg;
                count_reg     <= res_count_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            item_reg <= in_item;
        end
        if (state_reg == ST_EXEC)
        begin
            res_level_reg <= '0;
            res_store_reg <= store_reg;
            res_count_reg <= count_reg;
            case (item_reg.op)
                OP_SAMPLE:
                begin
                    // Drop the sample once the count has saturated
                    if (count_reg < CNT_MAX)
                    begin
                        res_store_reg <= sum[STORE_W] ? STORE_MAX : sum[STORE_W-1:0];
                        res_count_reg <= count_reg + 1'b1;
                    end
                end
                OP_MEASURE:
                begin
                    // Zero span: full scale for any net signal above zero; negative span: zero
                    if (span_zero && (net != '0))
                    begin
                        res_level_reg <= LEVEL_MAX;
                    end
                end
                OP_CLEAR:
                begin
                    res_store_reg <= '0;
                    res_count_reg <= '0;
                end
                default:
                begin
                    res_store_reg <= store_reg;
                end
            endcase
        end
        else if ((state_reg == ST_DIV) && div_status.done)
        begin
            if (item_reg.op == OP_AVERAGE)
            begin
                res_store_reg <= quotient;
            end
            else
            begin
                res_level_reg <= (quotient > {{(STORE_W-LEVEL_W){1'b0}}, LEVEL_MAX})
                               ? LEVEL_MAX : quotient[LEVEL_W-1:0];
            end
        end
        if ((state_reg == ST_FIN) && out_load)
        begin
            out_item_reg.scaled_level     <= res_level_reg;
            out_item_reg.raw_difference   <= diff;
            out_item_reg.background_level <= res_store_reg;
        end
    end

    uvbc_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (quotient)
    );

    assign in_ready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the UV background calibrator: directed table, random op sequences, scoreboard.
`timescale 1ns / 1ps

module tb;
    import uvbc_pkg::*;

    // Sample limit of the background accumulator (block default)
    localparam int MAX_BG_SAMPLES = 256;

    // Register indexes past the two real levels; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    // Run shape: random items, quiet tail with no idling, settle time at the end
    localparam int RANDOM_ITEMS  = 1700;
    localparam int CALM_TAIL     = 150;
    localparam int DRAIN_CYCLES  = 40;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int MAX_PRINTED   = 40;
    localparam int DIRECTED_ROWS = 32;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table. For a configuration row, a holds the write
    // data and index the register; for an item row, a and b are the two readings.
    // typed marks rows whose result is written out here instead of predicted.
    typedef struct packed {
        row_kind_t             kind;
        op_t                   op;
        logic [CFG_INDEX_W-1:0] index;
        logic [READING_W-1:0]  a;
        logic [READING_W-1:0]  b;
        logic                  typed;
        out_item_t             want;
    } dir_row_t;

    localparam out_item_t NO_LEVEL = '0;

    logic clk = 1'b0;
    logic rst_n;

    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [READING_W-1:0]   cfg_data;

    // Shadow state of the calibrator, kept in step with every accepted item
    logic [READING_W-1:0] white_ref;
    logic [READING_W-1:0] black_ref;
    logic [STORE_W-1:0]   bg_sum;
    logic [8:0]           bg_samples;

    // Results still owed by the block, oldest first
    out_item_t uv_results_due [$];

    int  mismatch_count = 0;
    int  rand_sent      = 0;
    bit  idle_on        = 1'b1;
    bit  calm           = 1'b0;

    // Directed part: reset state, field extremes, all four ops, the empty
    // average, the average that keeps its count, measurement below background,
    // zero span, negative span, ratio clamp and dropped register writes.
    dir_row_t directed [DIRECTED_ROWS] = '{
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd0,    1'b1, '{8'd0,   12'd0,    20'd0}},
        '{ROW_ITEM, OP_AVERAGE, REG_WHITE, 12'd5,    12'd3,    1'b1, '{8'd0,   12'd0,    20'd0}},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd4095, 1'b1, '{8'd255, 12'd4095, 20'd0}},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd4095, 12'd0,    1'b1, '{8'd0,   12'd0,    20'd0}},
        '{ROW_ITEM, OP_SAMPLE,  REG_WHITE, 12'd100,  12'd300,  1'b1, '{8'd0,   12'd200,  20'd200}},
        '{ROW_ITEM, OP_SAMPLE,  REG_WHITE, 12'd0,    12'd100,  1'b1, '{8'd0,   12'd100,  20'd300}},
        '{ROW_ITEM, OP_AVERAGE, REG_WHITE, 12'd7,    12'd7,    1'b1, '{8'd0,   12'd0,    20'd150}},
        '{ROW_ITEM, OP_SAMPLE,  REG_WHITE, 12'd0,    12'd50,   1'b1, '{8'd0,   12'd50,   20'd200}},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd150,  1'b1, '{8'd0,   12'd150,  20'd200}},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd1000, 12'd3000, 1'b0, NO_LEVEL},
        '{ROW_ITEM, OP_CLEAR,   REG_WHITE, 12'd4095, 12'd4095, 1'b1, '{8'd0,   12'd0,    20'd0}},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd2048, 1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_WHITE, 12'd1000, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_BLACK, 12'd1000, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd1,    1'b1, '{8'd255, 12'd1,    20'd0}},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd0,    1'b1, '{8'd0,   12'd0,    20'd0}},
        '{ROW_CFG,  OP_SAMPLE,  REG_WHITE, 12'd0,    12'd0,    1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_BLACK, 12'd4095, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd4095, 1'b1, '{8'd0,   12'd4095, 20'd0}},
        '{ROW_CFG,  OP_SAMPLE,  REG_WHITE, 12'd4095, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_BLACK, 12'd0,    12'd0,    1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_SPARE_2, 12'h800, 12'd0,   1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_SPARE_3, 12'h7FF, 12'd0,   1'b0, NO_LEVEL},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd1024, 1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_WHITE, 12'd2000, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_CFG,  OP_SAMPLE,  REG_BLACK, 12'd1000, 12'd0,    1'b0, NO_LEVEL},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd500,  1'b0, NO_LEVEL},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd4095, 1'b0, NO_LEVEL},
        '{ROW_ITEM, OP_SAMPLE,  REG_WHITE, 12'd0,    12'd4095, 1'b1, '{8'd0,   12'd4095, 20'd4095}},
        '{ROW_ITEM, OP_MEASURE, REG_WHITE, 12'd0,    12'd4095, 1'b1, '{8'd0,   12'd4095, 20'd4095}},
        '{ROW_ITEM, OP_AVERAGE, REG_WHITE, 12'd0,    12'd0,    1'b1, '{8'd0,   12'd0,    20'd4095}},
        '{ROW_ITEM, OP_CLEAR,   REG_WHITE, 12'd0,    12'd4095, 1'b1, '{8'd0,   12'd4095, 20'd0}}
    };

    uv_background_calibrator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one item to the shadow state and return the result it should give
    function automatic out_item_t calc_uv_result(input in_item_t it);
        out_item_t            res;
        logic [READING_W-1:0] diff;
        int unsigned          sum;
        int unsigned          net;
        int unsigned          span;
        int unsigned          q;
        res  = '0;
        // Negative difference clamps to zero
        diff = (it.second_reading >= it.first_reading) ?
               it.second_reading - it.first_reading : '0;
        res.raw_difference = diff;
        case (it.op)
            OP_SAMPLE:
            begin
                // Once the count is full, further samples leave everything alone
                if (bg_samples < MAX_BG_SAMPLES)
                begin
                    sum        = bg_sum + diff;
                    bg_sum     = (sum > STORE_MAX) ? STORE_MAX : sum[STORE_W-1:0];
                    bg_samples = bg_samples + 1'b1;
                end
            end
            OP_AVERAGE:
            begin
                // Count is kept, so later samples add onto the average
                if (bg_samples != 0)
                    bg_sum = bg_sum / bg_samples;
            end
            OP_MEASURE:
            begin
                net = (diff > bg_sum) ? diff - bg_sum : 0;
                if (white_ref < black_ref)
                    res.scaled_level = '0;
                else if (white_ref == black_ref)
                    res.scaled_level = (net != 0) ? LEVEL_MAX : '0;
                else
                begin
                    span = white_ref - black_ref;
                    q    = (net << SCALE_SHIFT) / span;
                    res.scaled_level = (q > LEVEL_MAX) ? LEVEL_MAX : q[LEVEL_W-1:0];
                end
            end
            default:
            begin
                bg_sum     = '0;
                bg_samples = '0;
            end
        endcase
        res.background_level = bg_sum;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Offer one item, hold it until accepted, then record what it owes.
    // Valid is left high on return so a back-to-back item needs no toggle.
    task automatic push_item(input in_item_t it, input logic typed, input out_item_t want);
        int        gap;
        out_item_t guess;
        gap = (idle_on && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        guess = calc_uv_result(it);
        uv_results_due.push_back(typed ? want : guess);
    endtask

    task automatic push_rand(input op_t op, input int r1, input int r2);
        in_item_t it;
        it.op             = op;
        it.first_reading  = READING_W'(r1);
        it.second_reading = READING_W'(r2);
        push_item(it, 1'b0, NO_LEVEL);
        rand_sent++;
        if (rand_sent >= RANDOM_ITEMS - CALM_TAIL)
            calm = 1'b1;
    endtask

    // Background sample: mostly a small rise, sometimes a fall that clamps
    task automatic push_sample_item();
        int r1;
        int r2;
        r1 = $urandom_range(0, 3800);
        if ($urandom_range(0, 7) == 0)
            r2 = $urandom_range(0, r1);
        else
            r2 = r1 + $urandom_range(0, (4095 - r1 > 300) ? 300 : 4095 - r1);
        push_rand(OP_SAMPLE, r1, r2);
    endtask

    // Drop the input valid and wait until every owed result has been taken.
    // The queue is read at the falling edge so the check cannot race the scoreboard.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (uv_results_due.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write, caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [READING_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_WHITE)
            white_ref = data;
        else if (idx == REG_BLACK)
            black_ref = data;
    endtask

    // Result side: check each accepted item against the oldest owed result and
    // throttle out_ready in random bursts; no throttling in the quiet tail or in phases without idling.
    initial
    begin
        out_item_t want;
        int        stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (uv_results_due.size() == 0)
                    flag_mismatch($sformatf("result with nothing owed: %h", out_item));
                else
                begin
                    want = uv_results_due.pop_front();
                    if (out_item.scaled_level !== want.scaled_level)
                        flag_mismatch($sformatf("scaled_level %0d, want %0d",
                                                out_item.scaled_level, want.scaled_level));
                    if (out_item.raw_difference !== want.raw_difference)
                        flag_mismatch($sformatf("raw_difference %0d, want %0d",
                                                out_item.raw_difference, want.raw_difference));
                    if (out_item.background_level !== want.background_level)
                        flag_mismatch($sformatf("background_level %0d, want %0d",
                                                out_item.background_level,
                                                want.background_level));
                end
            end
            if (calm || !idle_on)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Stimulus: reset, directed table, then random phases of op sequences
    initial
    begin
        in_item_t it;
        bit       cfg_open;
        int       phase;
        int       lvl_w;
        int       lvl_b;
        int       n_samples;
        int       r1;
        int       r2;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WHITE;
        cfg_data  <= '0;

        // Shadow state matches the block after reset
        white_ref  = 12'd4095;
        black_ref  = 12'd0;
        bg_sum     = '0;
        bg_samples = '0;
        cfg_open   = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table; a run of configuration rows is written only once the
        // block has delivered everything owed, and valid drops when items resume.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    wait_drained();
                write_reg(directed[i].index, directed[i].a);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open  = 1'b0;
                end
                it.op             = directed[i].op;
                it.first_reading  = directed[i].a;
                it.second_reading = directed[i].b;
                push_item(it, directed[i].typed, directed[i].want);
            end
        end

        // Random part. Most phases are a calibration routine: clear, a run of
        // background samples, fix the average, then a handful of measurements.
        // The first routine and a rare later one reach or overrun the sample limit.
        // Some phases are plain noise with any op and any readings.
        phase = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            // New reference levels between phases, only with the block drained
            if (phase != 0 && $urandom_range(0, 3) == 0)
            begin
                wait_drained();
                case ($urandom_range(0, 5))
                    0:
                    begin
                        lvl_w = 4095;
                        lvl_b = 0;
                    end
                    1:
                    begin
                        lvl_w = $urandom_range(0, 4095);
                        lvl_b = lvl_w;
                    end
                    2:
                    begin
                        lvl_b = $urandom_range(1, 4095);
                        lvl_w = $urandom_range(0, lvl_b - 1);
                    end
                    3:
                    begin
                        lvl_w = $urandom_range(0, 4095);
                        lvl_b = $urandom_range(0, 4095);
                    end
                    default:
                    begin
                        lvl_b = $urandom_range(0, 1500);
                        lvl_w = $urandom_range(lvl_b + 1, 4095);
                    end
                endcase
                if ($urandom_range(0, 2) == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_3 : REG_SPARE_2,
                              READING_W'($urandom_range(0, 4095)));
                if ($urandom_range(0, 1) == 0)
                begin
                    write_reg(REG_WHITE, READING_W'(lvl_w));
                    write_reg(REG_BLACK, READING_W'(lvl_b));
                end
                else
                begin
                    write_reg(REG_BLACK, READING_W'(lvl_b));
                    write_reg(REG_WHITE, READING_W'(lvl_w));
                end
                cfg_valid <= 1'b0;
            end

            // Some phases run with no idling at all
            idle_on = ($urandom_range(0, 3) != 0);

            if (phase != 0 && $urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(5, 20))
                    push_rand(op_t'($urandom_range(0, 3)),
                              $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
            else
            begin
                // Skip the clear now and then so state carries across routines
                if (phase == 0 || $urandom_range(0, 4) != 0)
                    push_rand(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
                n_samples = (phase == 0 || $urandom_range(0, 39) == 0) ?
                            $urandom_range(256, 264) : $urandom_range(1, 24);
                repeat (n_samples) push_sample_item();
                if ($urandom_range(0, 7) != 0)
                    push_rand(OP_AVERAGE, $urandom_range(0, 4095), $urandom_range(0, 4095));
                // Extra samples on top of the average, sometimes averaged again
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 4)) push_sample_item();
                    if ($urandom_range(0, 1) == 0)
                        push_rand(OP_AVERAGE, $urandom_range(0, 4095),
                                  $urandom_range(0, 4095));
                end
                repeat ($urandom_range(1, 10))
                begin
                    r1 = $urandom_range(0, 2000);
                    r2 = ($urandom_range(0, 7) == 0) ?
                         $urandom_range(0, r1) : $urandom_range(r1, 4095);
                    push_rand(OP_MEASURE, r1, r2);
                end
            end
            phase++;
        end

        // Let the last results out, then give the block time to show anything extra
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* uv_background_calibrator.f */
design/uvbc_pkg.sv
design/uvbc_serial_div.sv
design/uv_background_calibrator.sv
verif/tb.sv
